// ===== rtl/mtsb_pkg.sv =====
// Package for the metatile tilemap strip builder.
// Holds command and kind codes, register indexes, default sizes and the
// control/status and pipeline sideband structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtsb_pkg;

	localparam int MAP_BYTES_DEF   = 16384;
	localparam int TABLE_WORDS_DEF = 1024;
	localparam int COLUMN_LENGTH   = 16;
	localparam int ROW_LENGTH      = 32;

	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 14;
	localparam int DATA_W     = 16;
	localparam int TILE_W     = 10;
	localparam int SCREENS_W  = 5;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CMD_W-1:0] CMD_WR_MAP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_TABLE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD_COL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BUILD_ROW = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

	localparam logic [1:0] KIND_MAP_WR = 2'd0;
	localparam logic [1:0] KIND_TBL_WR = 2'd1;
	localparam logic [1:0] KIND_ELEM   = 2'd2;

	typedef struct packed {
		logic              load;
		logic              issue_wr;
		logic              issue_el;
		logic [STEP_W-1:0] step;
		logic              last;
	} ctl_t;

	typedef struct packed {
		logic adv;
	} sts_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       on;
		logic [3:0] slot;
		logic       half;
		logic       last;
		logic       odd;
		logic       row;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/mtsb_if.sv =====
// Valid/ready channel interfaces for the strip builder: command words in,
// result words out. Depends on mtsb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mtsb_in_if;
	logic                                valid;
	logic                                ready;
	logic [mtsb_pkg::CMD_W-1:0]          command;
	logic [mtsb_pkg::ADDR_W-1:0]         store_address;
	logic [mtsb_pkg::DATA_W-1:0]         store_data;
	logic signed [mtsb_pkg::TILE_W-1:0]  start_tile_x;
	logic signed [mtsb_pkg::TILE_W-1:0]  start_tile_y;
	logic                                odd_half;

	modport source (output valid, command, store_address, store_data, start_tile_x,
		start_tile_y, odd_half, input ready);
	modport sink (input valid, command, store_address, store_data, start_tile_x,
		start_tile_y, odd_half, output ready);
endinterface

interface mtsb_out_if;
	logic                        valid;
	logic                        ready;
	logic                        target_half;
	logic [3:0]                  slot;
	logic [mtsb_pkg::DATA_W-1:0] first_word;
	logic [mtsb_pkg::DATA_W-1:0] second_word;
	logic                        last;

	modport source (output valid, target_half, slot, first_word, second_word, last,
		input ready);
	modport sink (input valid, target_half, slot, first_word, second_word, last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/metatile_tilemap_strip_builder.sv =====
// A build command is latched when accepted; each tile step then passes
// through the pipeline. Throughput: one result word or store write per
// cycle while the output is not stalled. A build holds the input off for
// all its tile steps, set by the step sequencer; writes are taken when idle.
// Reset: async active low; clears control and sets both map size registers
// to 1. Map store and tile table are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module metatile_tilemap_strip_builder #(
	parameter int MAP_BYTES   = mtsb_pkg::MAP_BYTES_DEF,
	parameter int TABLE_WORDS = mtsb_pkg::TABLE_WORDS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	mtsb_in_if.sink                               in_ch,
	mtsb_out_if.source                            out_ch,
	input  wire logic                             cfg_we,
	input  wire logic [mtsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mtsb_pkg::SCREENS_W-1:0]   cfg_data
);

	mtsb_pkg::ctl_t ctl;
	mtsb_pkg::sts_t sts;

	mtsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.sts    (sts),
		.ctl    (ctl)
	);

	mtsb_dp #(
		.MAP_BYTES   (MAP_BYTES),
		.TABLE_WORDS (TABLE_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ctl           (ctl),
		.sts           (sts),
		.command       (in_ch.command),
		.store_address (in_ch.store_address),
		.store_data    (in_ch.store_data),
		.start_tile_x  (in_ch.start_tile_x),
		.start_tile_y  (in_ch.start_tile_y),
		.odd_half      (in_ch.odd_half),
		.out_ch        (out_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/mtsb_ctrl.sv =====
// Strip builder controller: accepts command words, sequences build steps.
// Depends on mtsb_pkg and mtsb_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mtsb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mtsb_in_if.sink             in_ch,
	input  wire mtsb_pkg::sts_t sts,
	output mtsb_pkg::ctl_t      ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                        state_q;
	logic                        row_q;
	logic [mtsb_pkg::STEP_W-1:0] cnt_q;
	logic                        accept;
	logic                        is_build;
	logic                        last_step;

	assign in_ch.ready = (state_q == ST_IDLE) && sts.adv;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_build    = (in_ch.command == mtsb_pkg::CMD_BUILD_COL) ||
		(in_ch.command == mtsb_pkg::CMD_BUILD_ROW);
	assign last_step   = row_q ?
		(cnt_q == mtsb_pkg::STEP_W'(mtsb_pkg::ROW_LENGTH - 1)) :
		(cnt_q == mtsb_pkg::STEP_W'(mtsb_pkg::COLUMN_LENGTH - 1));

	always_comb begin
		ctl.load     = accept && is_build;
		ctl.issue_wr = accept && !is_build;
		ctl.issue_el = (state_q == ST_RUN) && sts.adv;
		ctl.step     = cnt_q;
		ctl.last     = last_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && is_build) begin
						state_q <= ST_RUN;
						row_q   <= (in_ch.command == mtsb_pkg::CMD_BUILD_ROW);
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (sts.adv) begin
						if (last_step) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mtsb_dp.sv =====
// Strip builder datapath: config registers, tile position and map address,
// modulo reduction, map store and tile table, five-stage stallable pipeline.
// Depends on mtsb_pkg and mtsb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mtsb_dp #(
	parameter int MAP_BYTES   = mtsb_pkg::MAP_BYTES_DEF,
	parameter int TABLE_WORDS = mtsb_pkg::TABLE_WORDS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [mtsb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mtsb_pkg::SCREENS_W-1:0]       cfg_data,
	input  wire mtsb_pkg::ctl_t                       ctl,
	output mtsb_pkg::sts_t                            sts,
	input  wire logic [mtsb_pkg::CMD_W-1:0]           command,
	input  wire logic [mtsb_pkg::ADDR_W-1:0]          store_address,
	input  wire logic [mtsb_pkg::DATA_W-1:0]          store_data,
	input  wire logic signed [mtsb_pkg::TILE_W-1:0]   start_tile_x,
	input  wire logic signed [mtsb_pkg::TILE_W-1:0]   start_tile_y,
	input  wire logic                                 odd_half,
	mtsb_out_if.source                                out_ch
);

	// raw map address width and exact reciprocal for mod MAP_BYTES
	localparam int          MA_W    = 18;
	localparam int          MB      = $clog2(MAP_BYTES);
	localparam int          SH_M    = MA_W + MB;
	localparam int          QM_W    = MA_W - MB + 1;
	localparam logic [63:0] POW_M   = 64'd1 << SH_M;
	localparam logic [63:0] RECIP_M = (POW_M + 64'(MAP_BYTES) - 64'd1) / 64'(MAP_BYTES);

	// raw table index width and exact reciprocal for mod TABLE_WORDS
	localparam int          TA_W    = mtsb_pkg::ADDR_W;
	localparam int          TB      = $clog2(TABLE_WORDS);
	localparam int          SH_T    = TA_W + TB;
	localparam int          QT_W    = TA_W - TB + 1;
	localparam logic [63:0] POW_T   = 64'd1 << SH_T;
	localparam logic [63:0] RECIP_T = (POW_T + 64'(TABLE_WORDS) - 64'd1) / 64'(TABLE_WORDS);

	logic [mtsb_pkg::SCREENS_W-1:0]     width_q;
	logic [mtsb_pkg::SCREENS_W-1:0]     height_q;
	logic signed [mtsb_pkg::TILE_W-1:0] sx_q;
	logic signed [mtsb_pkg::TILE_W-1:0] sy_q;
	logic                               odd_q;
	logic                               row_q;

	logic                               adv;

	logic [10:0]                        x0;
	logic [10:0]                        y0;
	logic                               on0;
	logic [9:0]                         yhw0;
	logic [MA_W-1:0]                    a0;

	logic                               v_s1, v_s2, v_s3, v_s4, v_s5;
	mtsb_pkg::side_t                    side0, side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [MA_W-1:0]                    a_s1, a_s2;
	logic [TA_W-1:0]                    a_s3;
	logic [mtsb_pkg::DATA_W-1:0]        data_s1, data_s2, data_s3, data_s4;
	logic [QM_W-1:0]                    qm_s2;
	logic [7:0]                         byte_s3;
	logic [TA_W-1:0]                    r0_s4, r1_s4;
	logic [QT_W-1:0]                    qt0_s4, qt1_s4;
	logic [mtsb_pkg::DATA_W-1:0]        w0_s5, w1_s5;

	logic [2*MA_W:0]                    pm;
	logic [MA_W-1:0]                    mfull;
	logic [MB-1:0]                      mi;
	logic [1:0]                         off0, off1;
	logic [TA_W-1:0]                    r0, r1;
	logic [2*TA_W:0]                    pt0, pt1;
	logic [TA_W-1:0]                    tfull0, tfull1;
	logic [TB-1:0]                      ti0, ti1;

	logic [7:0]                         map_mem [MAP_BYTES];
	logic [mtsb_pkg::DATA_W-1:0]        tbl_mem [TABLE_WORDS];

	assign out_ch.valid = v_s5 && (side_s5.kind == mtsb_pkg::KIND_ELEM);
	assign adv          = !out_ch.valid || out_ch.ready;
	assign sts.adv      = adv;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mtsb_pkg::SCREENS_W'(1);
			height_q <= mtsb_pkg::SCREENS_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == mtsb_pkg::REG_MAP_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == mtsb_pkg::REG_MAP_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sx_q  <= start_tile_x;
			sy_q  <= start_tile_y;
			odd_q <= odd_half;
			row_q <= (command == mtsb_pkg::CMD_BUILD_ROW);
		end
	end

	// tile position of the current step, on-map test, raw map address
	always_comb begin
		x0   = {sx_q[9], sx_q} + (row_q ? {6'd0, ctl.step} : 11'd0);
		y0   = {sy_q[9], sy_q} + (row_q ? 11'd0 : {6'd0, ctl.step});
		on0  = !x0[10] && !y0[10] && (x0[9:0] < {1'b0, width_q, 4'd0}) &&
			(y0[9:0] < {1'b0, height_q, 4'd0});
		yhw0 = 10'(y0[8:4] * width_q);
		a0   = {yhw0, 8'd0} + {5'd0, x0[8:4], 8'd0} + {10'd0, y0[3:0], x0[3:0]};

		side0.kind = mtsb_pkg::KIND_ELEM;
		side0.on   = on0;
		side0.slot = row_q ? x0[3:0] : y0[3:0];
		side0.half = x0[4];
		side0.last = ctl.last;
		side0.odd  = odd_q;
		side0.row  = row_q;
		if (ctl.issue_wr) begin
			side0.kind = (command == mtsb_pkg::CMD_WR_MAP) ?
				mtsb_pkg::KIND_MAP_WR : mtsb_pkg::KIND_TBL_WR;
		end
	end

	// stage 2 quotient, stage 3 remainder for map address
	assign pm    = a_s1 * RECIP_M[MA_W:0];
	assign mfull = a_s2 - MA_W'(qm_s2 * MAP_BYTES);
	assign mi    = mfull[MB-1:0];

	// stage 4 raw table indexes and quotients, stage 5 remainders
	always_comb begin
		off0 = side_s3.row ? {side_s3.odd, 1'b0} : {1'b0, side_s3.odd};
		off1 = side_s3.row ? {side_s3.odd, 1'b1} : {1'b1, side_s3.odd};
		if (side_s3.kind == mtsb_pkg::KIND_TBL_WR) begin
			r0 = a_s3;
			r1 = a_s3;
		end else begin
			r0 = {4'd0, byte_s3, off0};
			r1 = {4'd0, byte_s3, off1};
		end
	end

	assign pt0    = r0 * RECIP_T[TA_W:0];
	assign pt1    = r1 * RECIP_T[TA_W:0];
	assign tfull0 = r0_s4 - TA_W'(qt0_s4 * TABLE_WORDS);
	assign tfull1 = r1_s4 - TA_W'(qt1_s4 * TABLE_WORDS);
	assign ti0    = tfull0[TB-1:0];
	assign ti1    = tfull1[TB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ctl.issue_wr || ctl.issue_el;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side0;
			a_s1    <= ctl.issue_wr ? {4'd0, store_address} : a0;
			data_s1 <= store_data;

			side_s2 <= side_s1;
			a_s2    <= a_s1;
			data_s2 <= data_s1;
			qm_s2   <= pm[2*MA_W:SH_M];

			side_s3 <= side_s2;
			a_s3    <= a_s2[TA_W-1:0];
			data_s3 <= data_s2;

			side_s4 <= side_s3;
			data_s4 <= data_s3;
			r0_s4   <= r0;
			r1_s4   <= r1;
			qt0_s4  <= pt0[2*TA_W:SH_T];
			qt1_s4  <= pt1[2*TA_W:SH_T];

			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2 && (side_s2.kind == mtsb_pkg::KIND_MAP_WR)) begin
				map_mem[mi] <= data_s2[7:0];
			end
			byte_s3 <= map_mem[mi];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s4 && (side_s4.kind == mtsb_pkg::KIND_TBL_WR)) begin
				tbl_mem[ti0] <= data_s4;
			end
			w0_s5 <= tbl_mem[ti0];
			w1_s5 <= tbl_mem[ti1];
		end
	end

	assign out_ch.target_half = side_s5.half;
	assign out_ch.slot        = side_s5.slot;
	assign out_ch.first_word  = side_s5.on ? w0_s5 : '0;
	assign out_ch.second_word = side_s5.on ? w1_s5 : '0;
	assign out_ch.last        = side_s5.last;

endmodule

`default_nettype wire

// ===== dv/tb_metatile_tilemap_strip_builder.sv =====
// Testbench for metatile_tilemap_strip_builder: random command words with a self-checking
// predictor of map and table writes and column/row strip builds.
// Depends on rtl/mtsb_pkg.sv, rtl/mtsb_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_metatile_tilemap_strip_builder;

	localparam int MB_W = $clog2(mtsb_pkg::MAP_BYTES_DEF);
	localparam int TB_W = $clog2(mtsb_pkg::TABLE_WORDS_DEF);

	typedef struct packed {
		logic [mtsb_pkg::CMD_W-1:0]         command;
		logic [mtsb_pkg::ADDR_W-1:0]        store_address;
		logic [mtsb_pkg::DATA_W-1:0]        store_data;
		logic signed [mtsb_pkg::TILE_W-1:0] start_tile_x;
		logic signed [mtsb_pkg::TILE_W-1:0] start_tile_y;
		logic                               odd_half;
	} cmd_word_t;

	typedef struct packed {
		logic                        target_half;
		logic [3:0]                  slot;
		logic [mtsb_pkg::DATA_W-1:0] first_word;
		logic [mtsb_pkg::DATA_W-1:0] second_word;
		logic                        last;
	} tile_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mtsb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mtsb_pkg::SCREENS_W-1:0] cfg_data;

	mtsb_in_if  in_ch();
	mtsb_out_if out_ch();

	metatile_tilemap_strip_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic [7:0]                  map_img [mtsb_pkg::MAP_BYTES_DEF];
	logic [mtsb_pkg::DATA_W-1:0] tbl_img [mtsb_pkg::TABLE_WORDS_DEF];
	int                          scr_w;
	int                          scr_h;

	// stimulus-side view of which store entries hold data
	bit   map_set [mtsb_pkg::MAP_BYTES_DEF];
	bit   tbl_set [mtsb_pkg::TABLE_WORDS_DEF];
	logic [7:0] map_plan [mtsb_pkg::MAP_BYTES_DEF];

	cmd_word_t  cmd_backlog[$];
	tile_pair_t tile_pairs_due[$];
	cmd_word_t  cur;
	cmd_word_t  seen;
	tile_pair_t got;
	tile_pair_t want;
	int         fail_cnt = 0;
	bit         calm;
	bit         hold_trig;
	int         hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit on_map(int x, int y);
		return x >= 0 && y >= 0 && x < 16 * scr_w && y < 16 * scr_h;
	endfunction

	function automatic int tile_addr(int x, int y);
		return ((y >> 4) * scr_w * 256 + (x >> 4) * 256 + (y & 15) * 16 + (x & 15))
			% mtsb_pkg::MAP_BYTES_DEF;
	endfunction

	task automatic build_strip(input cmd_word_t c);
		int sx, sy, n, x, y, q, k0, k1;
		tile_pair_t p;
		sx = $signed(c.start_tile_x);
		sy = $signed(c.start_tile_y);
		case (c.command)
			mtsb_pkg::CMD_WR_MAP: begin
				map_img[MB_W'(c.store_address % mtsb_pkg::MAP_BYTES_DEF)] = c.store_data[7:0];
			end
			mtsb_pkg::CMD_WR_TABLE: begin
				tbl_img[TB_W'(c.store_address % mtsb_pkg::TABLE_WORDS_DEF)] = c.store_data;
			end
			default: begin
				n = (c.command == mtsb_pkg::CMD_BUILD_COL) ? mtsb_pkg::COLUMN_LENGTH :
					mtsb_pkg::ROW_LENGTH;
				for (int i = 0; i < n; i++) begin
					if (c.command == mtsb_pkg::CMD_BUILD_COL) begin
						x = sx;
						y = sy + i;
						p.target_half = 1'(((sx + 512) >> 4) & 1);
						p.slot = 4'((y + 1024) & 15);
						k0 = c.odd_half ? 1 : 0;
						k1 = c.odd_half ? 3 : 2;
					end else begin
						x = sx + i;
						y = sy;
						p.target_half = 1'(((x + 1024) >> 4) & 1);
						p.slot = 4'((x + 1024) & 15);
						k0 = c.odd_half ? 2 : 0;
						k1 = c.odd_half ? 3 : 1;
					end
					if (on_map(x, y)) begin
						q = int'(map_img[MB_W'(tile_addr(x, y))]) * 4;
						p.first_word = tbl_img[TB_W'((q + k0) % mtsb_pkg::TABLE_WORDS_DEF)];
						p.second_word = tbl_img[TB_W'((q + k1) % mtsb_pkg::TABLE_WORDS_DEF)];
					end else begin
						p.first_word = '0;
						p.second_word = '0;
					end
					p.last = (i == n - 1);
					tile_pairs_due.push_back(p);
				end
			end
		endcase
	endtask

	task automatic push_write(logic [mtsb_pkg::CMD_W-1:0] cmd, int addr, int data);
		cmd_word_t c;
		c.command = cmd;
		c.store_address = mtsb_pkg::ADDR_W'(addr);
		c.store_data = mtsb_pkg::DATA_W'(data);
		c.start_tile_x = mtsb_pkg::TILE_W'($urandom);
		c.start_tile_y = mtsb_pkg::TILE_W'($urandom);
		c.odd_half = 1'($urandom);
		if (cmd == mtsb_pkg::CMD_WR_MAP) begin
			map_set[MB_W'(addr % mtsb_pkg::MAP_BYTES_DEF)] = 1'b1;
			map_plan[MB_W'(addr % mtsb_pkg::MAP_BYTES_DEF)] = data[7:0];
		end else begin
			tbl_set[TB_W'(addr % mtsb_pkg::TABLE_WORDS_DEF)] = 1'b1;
		end
		cmd_backlog.push_back(c);
	endtask

	// loads any map byte or table word the build would read before queuing it
	task automatic push_build(logic [mtsb_pkg::CMD_W-1:0] cmd, int sx, int sy, bit odd);
		cmd_word_t c;
		int n, x, y, a, b, fb;
		n = (cmd == mtsb_pkg::CMD_BUILD_COL) ? mtsb_pkg::COLUMN_LENGTH : mtsb_pkg::ROW_LENGTH;
		for (int i = 0; i < n; i++) begin
			x = (cmd == mtsb_pkg::CMD_BUILD_COL) ? sx : sx + i;
			y = (cmd == mtsb_pkg::CMD_BUILD_COL) ? sy + i : sy;
			if (on_map(x, y)) begin
				a = tile_addr(x, y);
				if (!map_set[MB_W'(a)]) begin
					fb = $urandom_range(3);
					if (fb == 3)
						fb = 255;
					push_write(mtsb_pkg::CMD_WR_MAP, a, int'($urandom_range(255) << 8) | fb);
				end
				b = int'(map_plan[MB_W'(a)]) * 4;
				for (int k = 0; k < 4; k++)
					if (!tbl_set[TB_W'(b + k)])
						push_write(mtsb_pkg::CMD_WR_TABLE,
							b + k + mtsb_pkg::TABLE_WORDS_DEF * int'($urandom_range(15)),
							int'($urandom_range(65535)));
			end
		end
		c.command = cmd;
		c.store_address = mtsb_pkg::ADDR_W'($urandom);
		c.store_data = mtsb_pkg::DATA_W'($urandom);
		c.start_tile_x = mtsb_pkg::TILE_W'(sx);
		c.start_tile_y = mtsb_pkg::TILE_W'(sy);
		c.odd_half = odd;
		cmd_backlog.push_back(c);
	endtask

	// builds mostly revisit the edge rows and columns of the first screens
	task automatic run_phase(int n);
		int r, sx, sy;
		bit row;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 12) begin
				push_write(mtsb_pkg::CMD_WR_MAP, int'($urandom_range(16383)),
					int'($urandom_range(65535)));
			end else if (r < 22) begin
				push_write(mtsb_pkg::CMD_WR_TABLE, int'($urandom_range(16383)),
					int'($urandom_range(65535)));
			end else begin
				row = 1'($urandom_range(1));
				if ($urandom_range(7) == 0) begin
					sx = int'($urandom_range(1023)) - 512;
					sy = int'($urandom_range(1023)) - 512;
				end else if (row) begin
					sx = int'($urandom_range(32)) - 32;
					sy = ($urandom_range(1) != 0) ? 15 : 0;
				end else begin
					sx = ($urandom_range(1) != 0) ? 15 : 0;
					sy = int'($urandom_range(16)) - 16;
				end
				push_build(row ? mtsb_pkg::CMD_BUILD_ROW : mtsb_pkg::CMD_BUILD_COL, sx, sy,
					1'($urandom_range(1)));
			end
		end
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || in_ch.valid === 1'b1 || tile_pairs_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [mtsb_pkg::CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[mtsb_pkg::SCREENS_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mtsb_pkg::REG_MAP_WIDTH)
			scr_w = val;
		else
			scr_h = val;
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= '0;
			in_ch.store_address <= '0;
			in_ch.store_data <= '0;
			in_ch.start_tile_x <= '0;
			in_ch.start_tile_y <= '0;
			in_ch.odd_half <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
				cur = cmd_backlog.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.command <= cur.command;
				in_ch.store_address <= cur.store_address;
				in_ch.store_data <= cur.store_data;
				in_ch.start_tile_x <= cur.start_tile_x;
				in_ch.start_tile_y <= cur.start_tile_y;
				in_ch.odd_half <= cur.odd_half;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_trig)
			hold_left <= 400;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.target_half = out_ch.target_half;
				got.slot = out_ch.slot;
				got.first_word = out_ch.first_word;
				got.second_word = out_ch.second_word;
				got.last = out_ch.last;
				if (tile_pairs_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected word half=%0d slot=%0d w0=%h w1=%h last=%0d",
							$time, got.target_half, got.slot, got.first_word,
							got.second_word, got.last);
				end else begin
					want = tile_pairs_due.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display({"%0t: mismatch exp half=%0d slot=%0d w0=%h w1=%h last=%0d",
								" got half=%0d slot=%0d w0=%h w1=%h last=%0d"}, $time,
								want.target_half, want.slot, want.first_word,
								want.second_word, want.last, got.target_half, got.slot,
								got.first_word, got.second_word, got.last);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				seen.command = in_ch.command;
				seen.store_address = in_ch.store_address;
				seen.store_data = in_ch.store_data;
				seen.start_tile_x = in_ch.start_tile_x;
				seen.start_tile_y = in_ch.start_tile_y;
				seen.odd_half = in_ch.odd_half;
				build_strip(seen);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_trig = 1'b0;
		scr_w = 1;
		scr_h = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: store extremes, both halves, off-map edges and slot wrap
		push_write(mtsb_pkg::CMD_WR_MAP, 0, 16'hff00);
		push_write(mtsb_pkg::CMD_WR_MAP, 16383, 16'h00ff);
		push_write(mtsb_pkg::CMD_WR_TABLE, 16383, 16'hffff);
		push_write(mtsb_pkg::CMD_WR_TABLE, 0, 16'h0000);
		push_build(mtsb_pkg::CMD_BUILD_COL, 0, 0, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_COL, 0, 0, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_ROW, 0, 0, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_ROW, 0, 0, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_COL, -512, -512, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_ROW, 511, 511, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_COL, 15, -8, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_ROW, -16, 15, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_COL, -1, 0, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_ROW, 0, 16, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_COL, 16, 0, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_ROW, -512, 0, 1'b1);
		push_build(mtsb_pkg::CMD_BUILD_COL, 511, -512, 1'b0);
		push_build(mtsb_pkg::CMD_BUILD_ROW, 7, 3, 1'b1);
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, 16);
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, 16);
		// map address past the end of the store
		push_build(mtsb_pkg::CMD_BUILD_COL, 200, 96, 1'b1);
		calm = 1'b1;
		run_phase(10);
		wait_drained();
		calm = 1'b0;

		// receiver stalls long while the sender keeps offering
		run_phase(12);
		hold_trig = 1'b1;
		@(negedge clk);
		hold_trig = 1'b0;
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, 0);
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, 3);
		run_phase(9);
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, 11);
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, 2);
		run_phase(9);
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, 7);
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, 1);
		run_phase(9);
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, 1);
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, 16);
		run_phase(9);
		wait_drained();

		write_reg(mtsb_pkg::REG_MAP_WIDTH, int'($urandom_range(1, 16)));
		write_reg(mtsb_pkg::REG_MAP_HEIGHT, int'($urandom_range(1, 16)));
		run_phase(12);
		wait_drained();

		if (fail_cnt == 0 && tile_pairs_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mtsb_pkg.sv
rtl/mtsb_if.sv
rtl/mtsb_ctrl.sv
rtl/mtsb_dp.sv
rtl/metatile_tilemap_strip_builder.sv
dv/tb_metatile_tilemap_strip_builder.sv
